>>> rtl/bdts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdts_pkg
// Types and constants for the bitset domain trail stack.
// ----------------------------------------------------------------------------
package bdts_pkg;

  localparam int MAX_LEVELS_DEF = 128;
  localparam int DATA_W         = 64;
  localparam int CFG_W          = 7;

  typedef enum logic [3:0] {
    MODE_PUSH         = 4'd0,
    MODE_POP          = 4'd1,
    MODE_BIND         = 4'd2,
    MODE_REMOVE       = 4'd3,
    MODE_MARK         = 4'd4,
    MODE_CLEAR_MARK   = 4'd5,
    MODE_RESTRICT     = 4'd6,
    MODE_AND_NEW      = 4'd7,
    MODE_AND_OLD      = 4'd8,
    MODE_QUERY        = 4'd9,
    MODE_LIST_VALID   = 4'd10,
    MODE_LIST_REMOVED = 4'd11
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_OVERFLOW   = 2'd1,
    STATUS_UNDERFLOW  = 2'd2,
    STATUS_LIST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MIN,
    ST_MAX,
    ST_NEXT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [3:0]        mode;
    logic [5:0]        value;
    logic [DATA_W-1:0] mask_in;
  } in_t;

  typedef struct packed {
    logic [DATA_W-1:0] mask_out;
    logic [6:0]        size;
    logic              is_empty;
    logic [6:0]        min_value;
    logic [6:0]        max_value;
    logic              fully_marked;
    logic              contains;
    logic [6:0]        next_value;
    logic [5:0]        list_value;
    logic              last;
    logic [1:0]        status;
    logic [6:0]        level;
  } out_t;

endpackage

>>> rtl/bdts_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdts_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module bdts_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/bitset_domain_trail_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitset_domain_trail_stack
// Stack of 64-bit domain masks with push/pop trail levels and a mark mask.
//
// An operation is accepted when start is high and busy is low. Results come
// on out_item, each valid for exactly one cycle with out_valid high; the
// receiver cannot stall, so every result is a transfer in its strobe cycle.
// The current level's mask sits in a register; lower levels sit in a RAM
// that a push writes and a pop reads. One leading-zero scan unit is shared
// over the sequencer steps: min, max (on the reversed mask), next value,
// and then one listed value per cycle.
// Non-list operations give one result; list modes give one result per listed
// value, or a single empty-list result. busy stays high until the last
// result strobes, so a new operation can be accepted in that strobe cycle.
// cfg_we/cfg_data write domain_size while idle; it reloads the level zero
// mask. Reset gives level zero with all 64 values, an empty mark mask and
// no pending result; no clearing pass is needed.
// ----------------------------------------------------------------------------
module bitset_domain_trail_stack #(
  parameter int MAX_LEVELS = bdts_pkg::MAX_LEVELS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  bdts_pkg::in_t              in_item,
  output logic                       out_valid,
  output bdts_pkg::out_t             out_item,
  input  logic                       cfg_we,
  input  logic [bdts_pkg::CFG_W-1:0] cfg_data
);

  localparam int LW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int DW = bdts_pkg::DATA_W;
  localparam logic [LW-1:0] LEVEL_TOP = LW'(MAX_LEVELS - 1);

  function automatic logic [6:0] lzc64(input logic [DW-1:0] x);
    logic [DW-1:0] t;
    logic [6:0]    n;
    t = x;
    n = 7'd0;
    if (x == '0) begin
      n = 7'd64;
    end else begin
      for (int k = 5; k >= 0; k--) begin
        if ((t >> (64 - (1 << k))) == '0) begin
          n[k] = 1'b1;
          t    = t << (1 << k);
        end
      end
    end
    return n;
  endfunction

  function automatic logic [6:0] popcnt64(input logic [DW-1:0] x);
    logic [DW-1:0] c;
    c = x - ((x >> 1) & 64'h5555_5555_5555_5555);
    c = (c & 64'h3333_3333_3333_3333) + ((c >> 2) & 64'h3333_3333_3333_3333);
    c = (c + (c >> 4)) & 64'h0F0F_0F0F_0F0F_0F0F;
    c = c + (c >> 8);
    c = c + (c >> 16);
    c = c + (c >> 32);
    return c[6:0];
  endfunction

  bdts_pkg::state_t state_r, state_nxt;
  logic [LW-1:0]    level_r, level_nxt;
  logic [DW-1:0]    cur_r, cur_nxt;
  logic [DW-1:0]    mark_r, mark_nxt;
  logic [3:0]       op_r, op_nxt;
  logic [5:0]       val_r, val_nxt;
  logic [DW-1:0]    mask_r, mask_nxt;
  logic [DW-1:0]    shown_r, shown_nxt;
  logic [DW-1:0]    src_r, src_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [6:0]       min_r, min_nxt;
  logic [6:0]       max_r, max_nxt;
  logic [6:0]       next_r, next_nxt;
  logic [6:0]       size_r, size_nxt;
  logic             empty_r, empty_nxt;
  logic             full_r, full_nxt;
  logic             cont_r, cont_nxt;
  bdts_pkg::out_t   out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             ram_we;
  logic [LW-1:0]    ram_waddr;
  logic [DW-1:0]    ram_wdata;
  logic [LW-1:0]    ram_raddr;
  logic [DW-1:0]    ram_rdata;

  logic [DW-1:0]    val_bit;
  logic [DW-1:0]    above;
  logic [DW-1:0]    cur_rev;
  logic [DW-1:0]    scan_op;
  logic [6:0]       scan_cnt;
  logic [DW-1:0]    src_clr;
  logic [DW-1:0]    init_mask;
  logic             is_list;
  logic             accept;

  bdts_ram #(
    .WIDTH(DW),
    .DEPTH(MAX_LEVELS)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign busy      = (state_r != bdts_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign ram_raddr = level_r - 1'b1;

  assign val_bit = 64'h8000_0000_0000_0000 >> val_r;
  assign above   = (64'd1 << (~val_r)) - 64'd1;
  assign is_list = (op_r == bdts_pkg::MODE_LIST_VALID) ||
                   (op_r == bdts_pkg::MODE_LIST_REMOVED);

  always_comb begin
    for (int i = 0; i < DW; i++) begin
      cur_rev[i] = cur_r[DW-1-i];
    end
  end

  // shared scan unit
  always_comb begin
    unique case (state_r)
      bdts_pkg::ST_MAX:  scan_op = cur_rev;
      bdts_pkg::ST_NEXT: scan_op = cur_r & above;
      bdts_pkg::ST_EMIT: scan_op = src_r;
      default:           scan_op = cur_r;
    endcase
  end
  assign scan_cnt = lzc64(scan_op);
  assign src_clr  = src_r & ~(64'h8000_0000_0000_0000 >> scan_cnt[5:0]);

  always_comb begin
    if (cfg_data == 7'd0) begin
      init_mask = '0;
    end else if (cfg_data >= 7'd64) begin
      init_mask = '1;
    end else begin
      init_mask = {DW{1'b1}} << (7'd64 - cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bdts_pkg::ST_IDLE;
      level_r     <= '0;
      cur_r       <= '1;
      mark_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      level_r     <= level_nxt;
      cur_r       <= cur_nxt;
      mark_r      <= mark_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    val_r    <= val_nxt;
    mask_r   <= mask_nxt;
    shown_r  <= shown_nxt;
    src_r    <= src_nxt;
    status_r <= status_nxt;
    min_r    <= min_nxt;
    max_r    <= max_nxt;
    next_r   <= next_nxt;
    size_r   <= size_nxt;
    empty_r  <= empty_nxt;
    full_r   <= full_nxt;
    cont_r   <= cont_nxt;
    out_r    <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    level_nxt     = level_r;
    cur_nxt       = cur_r;
    mark_nxt      = mark_r;
    op_nxt        = op_r;
    val_nxt       = val_r;
    mask_nxt      = mask_r;
    shown_nxt     = shown_r;
    src_nxt       = src_r;
    status_nxt    = status_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    next_nxt      = next_r;
    size_nxt      = size_r;
    empty_nxt     = empty_r;
    full_nxt      = full_r;
    cont_nxt      = cont_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = level_r;
    ram_wdata     = cur_r;

    unique case (state_r)
      bdts_pkg::ST_IDLE: begin
        if (cfg_we) begin
          if (level_r == '0) begin
            cur_nxt = init_mask;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = init_mask;
          end
        end
        if (accept) begin
          op_nxt    = in_item.mode;
          val_nxt   = in_item.value;
          mask_nxt  = in_item.mask_in;
          state_nxt = bdts_pkg::ST_EXEC;
        end
      end
      bdts_pkg::ST_EXEC: begin
        status_nxt = bdts_pkg::STATUS_OK;
        unique case (op_r)
          bdts_pkg::MODE_PUSH: begin
            if (level_r == LEVEL_TOP) begin
              status_nxt = bdts_pkg::STATUS_OVERFLOW;
            end else begin
              ram_we    = 1'b1;
              level_nxt = level_r + 1'b1;
            end
          end
          bdts_pkg::MODE_POP: begin
            if (level_r == '0) begin
              status_nxt = bdts_pkg::STATUS_UNDERFLOW;
            end else begin
              cur_nxt   = ram_rdata;
              level_nxt = level_r - 1'b1;
            end
          end
          bdts_pkg::MODE_BIND:       cur_nxt  = val_bit;
          bdts_pkg::MODE_REMOVE:     cur_nxt  = cur_r & ~val_bit;
          bdts_pkg::MODE_MARK:       mark_nxt = mark_r | val_bit;
          bdts_pkg::MODE_CLEAR_MARK: mark_nxt = '0;
          bdts_pkg::MODE_RESTRICT:   cur_nxt  = cur_r & mark_r;
          bdts_pkg::MODE_AND_NEW,
          bdts_pkg::MODE_AND_OLD:    cur_nxt  = cur_r & mask_r;
          default: ;
        endcase
        shown_nxt = (op_r == bdts_pkg::MODE_AND_OLD) ? cur_r : cur_nxt;
        if (op_r == bdts_pkg::MODE_LIST_VALID) begin
          src_nxt = cur_r;
        end else begin
          src_nxt = mask_r & ~cur_r;
        end
        state_nxt = bdts_pkg::ST_MIN;
      end
      bdts_pkg::ST_MIN: begin
        min_nxt   = scan_cnt;
        size_nxt  = popcnt64(cur_r);
        empty_nxt = (cur_r == '0);
        full_nxt  = (cur_r == mark_r);
        cont_nxt  = |(cur_r & val_bit);
        state_nxt = bdts_pkg::ST_MAX;
      end
      bdts_pkg::ST_MAX: begin
        max_nxt   = empty_r ? 7'd64 : 7'd63 - scan_cnt;
        state_nxt = bdts_pkg::ST_NEXT;
      end
      bdts_pkg::ST_NEXT: begin
        next_nxt  = scan_cnt;
        state_nxt = bdts_pkg::ST_EMIT;
      end
      bdts_pkg::ST_EMIT: begin
        out_valid_nxt         = 1'b1;
        out_nxt.mask_out      = shown_r;
        out_nxt.size          = size_r;
        out_nxt.is_empty      = empty_r;
        out_nxt.min_value     = min_r;
        out_nxt.max_value     = max_r;
        out_nxt.fully_marked  = full_r;
        out_nxt.contains      = cont_r;
        out_nxt.next_value    = next_r;
        out_nxt.level         = 7'(level_r);
        out_nxt.list_value    = 6'd0;
        out_nxt.last          = 1'b1;
        out_nxt.status        = status_r;
        priority if (!is_list) begin
          state_nxt = bdts_pkg::ST_IDLE;
        end else if (src_r == '0) begin
          out_nxt.status = bdts_pkg::STATUS_LIST_EMPTY;
          state_nxt      = bdts_pkg::ST_IDLE;
        end else begin
          out_nxt.list_value = scan_cnt[5:0];
          out_nxt.last       = (src_clr == '0);
          out_nxt.status     = bdts_pkg::STATUS_OK;
          src_nxt            = src_clr;
          if (src_clr == '0) begin
            state_nxt = bdts_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = bdts_pkg::ST_IDLE;
    endcase
  end

  a_strobe_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == bdts_pkg::ST_EMIT))
    else $error("result strobe without an emit step");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted transfer did not start the sequencer");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.last) |-> !busy)
    else $error("block still busy after the last result");

  a_empty_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.is_empty == (out_item.size == 7'd0)))
    else $error("empty flag disagrees with size");

  a_no_push_past_top: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bdts_pkg::ST_EXEC && op_r == bdts_pkg::MODE_PUSH &&
     level_r == LEVEL_TOP) |=> (level_r == LEVEL_TOP))
    else $error("push moved the level past the top");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for bitset_domain_trail_stack. A short table of
// directed operations runs first, then a sweep of the trail stack to its top
// and back down, then phases of random operations under several domain
// sizes. Every accepted operation runs through a golden model of the
// stack, and each result strobe is checked field by field against the
// oldest pending report.
// ----------------------------------------------------------------------------
module testbench;
  import bdts_pkg::*;

  localparam int LEVELS    = MAX_LEVELS_DEF;
  localparam int LIMIT     = 400000;
  localparam int SETTLE    = 8;
  localparam int PHASE_OPS = 16;
  localparam logic [3:0]  MODE_SPARE_FIRST = 4'd12;
  localparam logic [3:0]  MODE_SPARE_LAST  = 4'd15;
  localparam logic [63:0] ALL_ONES         = '1;
  localparam out_t        NO_REPORT        = '0;

  typedef struct packed {
    logic [3:0]  mode;
    logic [5:0]  value;
    logic [63:0] mask;
    logic        typed;
    out_t        want;
  } step_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             start;
  logic             busy;
  in_t              in_item;
  logic             out_valid;
  out_t             out_item;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_data;

  // golden copy of the domain state
  logic [63:0] trail [LEVELS];
  int unsigned depth;
  logic [63:0] marked;

  out_t  report_q [$];
  step_t plan_q [$];
  out_t  head;
  int    mismatches = 0;
  int    cycles = 0;

  bitset_domain_trail_stack dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] value_bit(logic [5:0] v);
    return 64'd1 << (6'd63 - v);
  endfunction

  function automatic logic [63:0] seed_mask(logic [6:0] n);
    int k;
    k = (n > 7'd64) ? 64 : int'(n);
    return (k == 0) ? 64'd0 : ALL_ONES << (64 - k);
  endfunction

  // smallest present value, 64 when the mask is empty
  function automatic logic [6:0] first_value(logic [63:0] m);
    for (int i = 0; i < 64; i++) begin
      if (m[63 - i]) return 7'(i);
    end
    return 7'd64;
  endfunction

  function automatic void post_report(out_t r);
    report_q.insert(report_q.size(), r);
  endfunction

  function automatic out_t domain_report(logic [63:0] shown, logic [5:0] v, logic [5:0] lv,
                                         logic last, status_t st);
    logic [63:0] d;
    logic [63:0] vb;
    out_t        r;
    int          cnt;
    int          low;
    d   = trail[depth];
    vb  = value_bit(v);
    cnt = 0;
    low = 64;
    for (int i = 63; i >= 0; i--) begin
      if (d[i]) begin
        cnt++;
        low = i;
      end
    end
    r.mask_out     = shown;
    r.size         = 7'(cnt);
    r.is_empty     = (d == 64'd0);
    r.min_value    = first_value(d);
    r.max_value    = (d == 64'd0) ? 7'd64 : 7'(63 - low);
    r.fully_marked = (d == marked);
    r.contains     = |(d & vb);
    r.next_value   = first_value(d & (vb - 64'd1));
    r.list_value   = lv;
    r.last         = last;
    r.status       = st;
    r.level        = depth[6:0];
    return r;
  endfunction

  function automatic void domain_apply(in_t op);
    logic [63:0] old;
    logic [63:0] src;
    logic [63:0] vb;
    status_t     st;
    old = trail[depth];
    vb  = value_bit(op.value);
    st  = STATUS_OK;
    case (op.mode)
      MODE_PUSH: begin
        if (depth + 1 >= LEVELS) begin
          st = STATUS_OVERFLOW;
        end else begin
          trail[depth + 1] = old;
          depth++;
        end
      end
      MODE_POP: begin
        if (depth == 0) st = STATUS_UNDERFLOW;
        else depth--;
      end
      MODE_BIND:                trail[depth] = vb;
      MODE_REMOVE:              trail[depth] = old & ~vb;
      MODE_MARK:                marked = marked | vb;
      MODE_CLEAR_MARK:          marked = 64'd0;
      MODE_RESTRICT:            trail[depth] = old & marked;
      MODE_AND_NEW, MODE_AND_OLD: trail[depth] = old & op.mask_in;
      MODE_LIST_VALID, MODE_LIST_REMOVED: begin
        src = (op.mode == MODE_LIST_VALID) ? old : (op.mask_in & ~old);
        if (src == 64'd0) begin
          post_report(domain_report(old, op.value, 6'd0, 1'b1, STATUS_LIST_EMPTY));
        end else begin
          for (int i = 0; i < 64; i++) begin
            if (src[63 - i]) begin
              post_report(domain_report(old, op.value, 6'(i),
                (src & (value_bit(6'(i)) - 64'd1)) == 64'd0, STATUS_OK));
            end
          end
        end
        return;
      end
      default: ;
    endcase
    post_report(domain_report((op.mode == MODE_AND_OLD) ? old : trail[depth],
                              op.value, 6'd0, 1'b1, st));
  endfunction

  function automatic out_t report_of(logic [63:0] m, logic [6:0] sz, logic emp,
                                     logic [6:0] mn, logic [6:0] mx, logic fm, logic ct,
                                     logic [6:0] nx, status_t st, logic [6:0] lv);
    out_t r;
    r = '{mask_out: m, size: sz, is_empty: emp, min_value: mn, max_value: mx,
          fully_marked: fm, contains: ct, next_value: nx, list_value: 6'd0,
          last: 1'b1, status: st, level: lv};
    return r;
  endfunction

  function automatic in_t make_op(logic [3:0] mode, logic [5:0] v, logic [63:0] m);
    in_t r;
    r.mode    = mode;
    r.value   = v;
    r.mask_in = m;
    return r;
  endfunction

  function automatic void add_row(step_t row);
    plan_q.insert(plan_q.size(), row);
  endfunction

  function automatic logic [63:0] rand_mask();
    int sel;
    sel = $urandom_range(0, 5);
    case (sel)
      0:       return ALL_ONES;
      1:       return 64'd0;
      2:       return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic in_t rand_op();
    int          pick;
    logic [3:0]  mode;
    logic [63:0] m;
    pick = $urandom_range(0, 99);
    if (pick < 12)      mode = MODE_PUSH;
    else if (pick < 22) mode = MODE_POP;
    else if (pick < 32) mode = MODE_BIND;
    else if (pick < 44) mode = MODE_REMOVE;
    else if (pick < 52) mode = MODE_MARK;
    else if (pick < 56) mode = MODE_CLEAR_MARK;
    else if (pick < 62) mode = MODE_RESTRICT;
    else if (pick < 70) mode = MODE_AND_NEW;
    else if (pick < 76) mode = MODE_AND_OLD;
    else if (pick < 84) mode = MODE_QUERY;
    else if (pick < 91) mode = MODE_LIST_VALID;
    else if (pick < 97) mode = MODE_LIST_REMOVED;
    else                mode = MODE_SPARE_FIRST + 4'($urandom_range(0, 3));
    m = rand_mask();
    if (mode == MODE_LIST_REMOVED && $urandom_range(0, 1) == 1) m = m | trail[depth];
    return make_op(mode, 6'($urandom_range(0, 63)), m);
  endfunction

  // called right after a falling edge, returns right after one
  task automatic send_op(input in_t op, input int gap, input logic typed, input out_t want);
    start   <= 1'b1;
    in_item <= op;
    @(posedge clk);
    while (busy) @(posedge clk);
    domain_apply(op);
    if (typed) report_q[report_q.size() - 1] = want;
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (report_q.size() != 0 || busy) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_size(input logic [6:0] n);
    cfg_we   <= 1'b1;
    cfg_data <= n;
    @(negedge clk);
    cfg_we   <= 1'b0;
    trail[0] = seed_mask(n);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %h got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (report_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected transfer, expected none got mask %h", $time,
                 out_item.mask_out);
      end else begin
        head = report_q.pop_front();
        check_field("mask_out", head.mask_out, out_item.mask_out);
        check_field("size", head.size, out_item.size);
        check_field("is_empty", head.is_empty, out_item.is_empty);
        check_field("min_value", head.min_value, out_item.min_value);
        check_field("max_value", head.max_value, out_item.max_value);
        check_field("fully_marked", head.fully_marked, out_item.fully_marked);
        check_field("contains", head.contains, out_item.contains);
        check_field("next_value", head.next_value, out_item.next_value);
        check_field("list_value", head.list_value, out_item.list_value);
        check_field("last", head.last, out_item.last);
        check_field("status", head.status, out_item.status);
        check_field("level", head.level, out_item.level);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [6:0] sizes [6];
    bit         burst;
    rst_n    = 1'b0;
    start    = 1'b0;
    cfg_we   = 1'b0;
    cfg_data = '0;
    in_item  = '0;
    burst    = 1'b0;
    foreach (trail[i]) trail[i] = 64'd0;
    trail[0] = seed_mask(7'd64);
    depth    = 0;
    marked   = 64'd0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    add_row('{MODE_QUERY, 6'd0, 64'd0, 1'b1,
      report_of(ALL_ONES, 7'd64, 1'b0, 7'd0, 7'd63, 1'b0, 1'b1, 7'd1, STATUS_OK, 7'd0)});
    add_row('{MODE_POP, 6'd63, 64'd0, 1'b1,
      report_of(ALL_ONES, 7'd64, 1'b0, 7'd0, 7'd63, 1'b0, 1'b1, 7'd64, STATUS_UNDERFLOW,
                7'd0)});
    add_row('{MODE_LIST_REMOVED, 6'd0, ALL_ONES, 1'b1,
      report_of(ALL_ONES, 7'd64, 1'b0, 7'd0, 7'd63, 1'b0, 1'b1, 7'd1, STATUS_LIST_EMPTY,
                7'd0)});
    add_row('{MODE_LIST_VALID, 6'd31, 64'd0, 1'b0, NO_REPORT});
    add_row('{MODE_SPARE_LAST, 6'd0, ALL_ONES, 1'b0, NO_REPORT});
    add_row('{MODE_PUSH, 6'd0, 64'd0, 1'b1,
      report_of(ALL_ONES, 7'd64, 1'b0, 7'd0, 7'd63, 1'b0, 1'b1, 7'd1, STATUS_OK, 7'd1)});
    add_row('{MODE_AND_OLD, 6'd5, 64'd0, 1'b1,
      report_of(ALL_ONES, 7'd0, 1'b1, 7'd64, 7'd64, 1'b1, 1'b0, 7'd64, STATUS_OK, 7'd1)});
    add_row('{MODE_LIST_VALID, 6'd0, 64'd0, 1'b1,
      report_of(64'd0, 7'd0, 1'b1, 7'd64, 7'd64, 1'b1, 1'b0, 7'd64, STATUS_LIST_EMPTY,
                7'd1)});
    add_row('{MODE_POP, 6'd0, ALL_ONES, 1'b0, NO_REPORT});
    add_row('{MODE_PUSH, 6'd40, 64'd0, 1'b0, NO_REPORT});
    add_row('{MODE_BIND, 6'd63, 64'd0, 1'b0, NO_REPORT});
    add_row('{MODE_LIST_REMOVED, 6'd0, ALL_ONES, 1'b0, NO_REPORT});
    add_row('{MODE_BIND, 6'd0, 64'd0, 1'b0, NO_REPORT});
    add_row('{MODE_MARK, 6'd0, 64'd0, 1'b0, NO_REPORT});
    add_row('{MODE_MARK, 6'd63, 64'd0, 1'b0, NO_REPORT});
    add_row('{MODE_QUERY, 6'd0, 64'd0, 1'b0, NO_REPORT});
    add_row('{MODE_POP, 6'd0, 64'd0, 1'b0, NO_REPORT});
    add_row('{MODE_RESTRICT, 6'd0, 64'd0, 1'b0, NO_REPORT});
    add_row('{MODE_QUERY, 6'd0, 64'd0, 1'b0, NO_REPORT});
    add_row('{MODE_LIST_VALID, 6'd0, 64'd0, 1'b0, NO_REPORT});
    add_row('{MODE_CLEAR_MARK, 6'd0, 64'd0, 1'b0, NO_REPORT});
    add_row('{MODE_AND_NEW, 6'd62, 64'h8000_0000_0000_0000, 1'b0, NO_REPORT});
    add_row('{MODE_REMOVE, 6'd0, 64'd0, 1'b0, NO_REPORT});
    add_row('{MODE_REMOVE, 6'd63, 64'd0, 1'b0, NO_REPORT});
    add_row('{MODE_SPARE_FIRST, 6'd63, 64'd0, 1'b0, NO_REPORT});

    foreach (plan_q[k]) begin
      send_op(make_op(plan_q[k].mode, plan_q[k].value, plan_q[k].mask),
              ($urandom_range(0, 1) == 1) ? $urandom_range(0, 19) : 0,
              plan_q[k].typed, plan_q[k].want);
    end
    drain();

    // climb the trail to the top level, overflow once, list there, come back down
    write_size(7'd127);
    while (depth < LEVELS - 1) begin
      send_op(make_op(MODE_PUSH, 6'($urandom_range(0, 63)), rand_mask()),
              $urandom_range(0, 2), 1'b0, NO_REPORT);
    end
    send_op(make_op(MODE_PUSH, 6'd0, 64'd0), 0, 1'b0, NO_REPORT);
    send_op(make_op(MODE_LIST_VALID, 6'd17, 64'd0), 0, 1'b0, NO_REPORT);
    while (depth > 0) begin
      send_op(make_op(MODE_POP, 6'($urandom_range(0, 63)), rand_mask()),
              $urandom_range(0, 2), 1'b0, NO_REPORT);
    end
    send_op(make_op(MODE_POP, 6'd0, 64'd0), 0, 1'b0, NO_REPORT);
    drain();

    sizes = '{7'd1, 7'd0, 7'd127, 7'd65, 7'd64, 7'd37};
    sizes[5] = 7'($urandom_range(2, 63));
    for (int p = 0; p < 6; p++) begin
      write_size(sizes[p]);
      for (int k = 0; k < PHASE_OPS; k++) begin
        if (k % 15 == 0) burst = ($urandom_range(0, 2) == 0);
        if (k == PHASE_OPS / 2) drain();
        send_op(rand_op(), burst ? 0 : $urandom_range(0, 19), 1'b0, NO_REPORT);
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

>>> sim.f
rtl/bdts_pkg.sv
rtl/bdts_ram.sv
rtl/bitset_domain_trail_stack.sv
tb/testbench.sv
